// File: hw/rtl/owb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the single-wire bus master.
// No dependencies; used by owb_cfg_regs, owb_engine and the top level.
package owb_pkg;

    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int TICK_W     = 10;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RST_LOW = 3'd1,
        PH_RST_REL = 3'd2,
        PH_RST_REC = 3'd3,
        PH_WR      = 3'd4,
        PH_RD_LOW  = 3'd5,
        PH_RD_REL  = 3'd6,
        PH_RD_REC  = 3'd7
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW   = 3'd0,
        REG_RESET_REL   = 3'd1,
        REG_RESET_REC   = 3'd2,
        REG_WRITE0_LOW  = 3'd3,
        REG_WRITE1_LOW  = 3'd4,
        REG_WRITE_SLOT  = 3'd5,
        REG_READ_REL    = 3'd6,
        REG_READ_REC    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [7:0] reset_release_us;
        logic [9:0] reset_recovery_us;
        logic [7:0] write0_low_us;
        logic [7:0] write1_low_us;
        logic [7:0] write_slot_us;
        logic [7:0] read_release_us;
        logic [7:0] read_recovery_us;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] tx_byte;
        logic       line_in;
    } tick_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       presence;
        logic       rejected;
    } res_t;

endpackage

// File: hw/rtl/owb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tick beats and result beats.
// Standalone; no package needed.
interface owb_tick_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] tx_byte;
    logic       line_in;

    modport source (output valid, output cmd, output tx_byte, output line_in, input ready);
    modport sink   (input valid, input cmd, input tx_byte, input line_in, output ready);
endinterface

interface owb_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       presence;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output rx_byte, output presence, output rejected, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input rx_byte, input presence, input rejected, output ready);
endinterface

// File: hw/rtl/owb_cfg_regs.sv
`timescale 1ns / 1ps
// Timing configuration registers, written through a plain write port.
// Depends on owb_pkg.
module owb_cfg_regs
    import owb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us      <= 10'd500;
            cfg_reg.reset_release_us  <= 8'd70;
            cfg_reg.reset_recovery_us <= 10'd400;
            cfg_reg.write0_low_us     <= 8'd60;
            cfg_reg.write1_low_us     <= 8'd5;
            cfg_reg.write_slot_us     <= 8'd65;
            cfg_reg.read_release_us   <= 8'd10;
            cfg_reg.read_recovery_us  <= 8'd40;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_RESET_LOW:  cfg_reg.reset_low_us      <= cfg_wdata;
                REG_RESET_REL:  cfg_reg.reset_release_us  <= cfg_wdata[7:0];
                REG_RESET_REC:  cfg_reg.reset_recovery_us <= cfg_wdata;
                REG_WRITE0_LOW: cfg_reg.write0_low_us     <= cfg_wdata[7:0];
                REG_WRITE1_LOW: cfg_reg.write1_low_us     <= cfg_wdata[7:0];
                REG_WRITE_SLOT: cfg_reg.write_slot_us     <= cfg_wdata[7:0];
                REG_READ_REL:   cfg_reg.read_release_us   <= cfg_wdata[7:0];
                REG_READ_REC:   cfg_reg.read_recovery_us  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/owb_engine.sv
`timescale 1ns / 1ps
// Bus timing state machine: advances one tick per step and forms the result.
// Depends on owb_pkg.
module owb_engine
    import owb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step_en,
    input  tick_t tick,
    input  cfg_t  cfg,
    output res_t  res
);

    phase_t            phase_reg, phase_next, ph_cur;
    logic [TICK_W-1:0] tick_reg, tick_next, tc_cur;
    logic [2:0]        bit_reg, bit_next, bi_cur;
    logic [7:0]        shift_reg, shift_next, sh_cur, sh_rd;
    logic              presence_reg, presence_next;
    logic [7:0]        rx_reg, rx_next;
    logic [TICK_W:0]   tc_inc;
    logic [7:0]        low_time;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            rx_reg       <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            rx_reg       <= rx_next;
        end
    end

    always_comb
    begin
        ph_cur = phase_reg;
        tc_cur = tick_reg;
        bi_cur = bit_reg;
        sh_cur = shift_reg;
        res    = '0;

        if (phase_reg == PH_IDLE)
        begin
            if (cmd_t'(tick.cmd) != CMD_TICK)
            begin
                tc_cur = '0;
                bi_cur = '0;
                unique case (cmd_t'(tick.cmd))
                    CMD_RESET: ph_cur = PH_RST_LOW;
                    CMD_WRITE:
                    begin
                        ph_cur = PH_WR;
                        sh_cur = tick.tx_byte;
                    end
                    CMD_READ:
                    begin
                        ph_cur = PH_RD_LOW;
                        sh_cur = '0;
                    end
                    default: ;
                endcase
            end
        end
        else if (cmd_t'(tick.cmd) != CMD_TICK)
        begin
            res.rejected = 1'b1;
        end

        res.busy_res = (ph_cur != PH_IDLE);

        phase_next    = ph_cur;
        tick_next     = tc_cur;
        bit_next      = bi_cur;
        shift_next    = sh_cur;
        presence_next = presence_reg;
        rx_next       = rx_reg;
        tc_inc        = {1'b0, tc_cur} + 1'b1;
        low_time      = sh_cur[0] ? cfg.write1_low_us : cfg.write0_low_us;
        sh_rd         = (tc_cur == '0) ? {tick.line_in, sh_cur[7:1]} : sh_cur;

        unique case (ph_cur)
            PH_IDLE: ;
            PH_RST_LOW:
            begin
                res.drive_low = 1'b1;
                if (tc_inc >= {1'b0, cfg.reset_low_us})
                begin
                    phase_next = PH_RST_REL;
                    tick_next  = '0;
                end
                else
                    tick_next = tc_inc[TICK_W-1:0];
            end
            PH_RST_REL:
            begin
                if (tc_inc >= {3'b0, cfg.reset_release_us})
                begin
                    phase_next = PH_RST_REC;
                    tick_next  = '0;
                end
                else
                    tick_next = tc_inc[TICK_W-1:0];
            end
            PH_RST_REC:
            begin
                if (tc_cur == '0)
                    presence_next = ~tick.line_in;
                if (tc_cur >= cfg.reset_recovery_us)
                begin
                    phase_next   = PH_IDLE;
                    tick_next    = '0;
                    bit_next     = '0;
                    res.done_res = 1'b1;
                end
                else
                    tick_next = tc_inc[TICK_W-1:0];
            end
            PH_WR:
            begin
                res.drive_low = (tc_cur < {2'b0, low_time});
                if (tc_inc >= {3'b0, cfg.write_slot_us})
                begin
                    shift_next = {1'b0, sh_cur[7:1]};
                    tick_next  = '0;
                    if (bi_cur == 3'd7)
                    begin
                        phase_next   = PH_IDLE;
                        bit_next     = '0;
                        res.done_res = 1'b1;
                    end
                    else
                        bit_next = bi_cur + 3'd1;
                end
                else
                    tick_next = tc_inc[TICK_W-1:0];
            end
            PH_RD_LOW:
            begin
                res.drive_low = 1'b1;
                phase_next    = PH_RD_REL;
                tick_next     = '0;
            end
            PH_RD_REL:
            begin
                if (tc_inc >= {3'b0, cfg.read_release_us})
                begin
                    phase_next = PH_RD_REC;
                    tick_next  = '0;
                end
                else
                    tick_next = tc_inc[TICK_W-1:0];
            end
            PH_RD_REC:
            begin
                shift_next = sh_rd;
                if (tc_cur >= {2'b0, cfg.read_recovery_us})
                begin
                    tick_next = '0;
                    if (bi_cur == 3'd7)
                    begin
                        rx_next      = sh_rd;
                        phase_next   = PH_IDLE;
                        bit_next     = '0;
                        res.done_res = 1'b1;
                    end
                    else
                    begin
                        bit_next   = bi_cur + 3'd1;
                        phase_next = PH_RD_LOW;
                    end
                end
                else
                    tick_next = tc_inc[TICK_W-1:0];
            end
            default: ;
        endcase

        res.rx_byte  = rx_next;
        res.presence = presence_next;
    end

endmodule

// File: hw/rtl/one_wire_bus_master_unit.sv
`timescale 1ns / 1ps
// Single-wire bus master timing engine, top level.
// Depends on owb_pkg, owb_if, owb_cfg_regs and owb_engine.
//
// Usage: each tick beat on the "tick" channel is one microsecond of bus
// time; it carries cmd (tick only, reset, write byte, read byte), tx_byte
// and the sampled bus level line_in. Every tick beat yields exactly one
// result beat on "res": drive_low for this tick, busy_res, done_res,
// rx_byte of the last read, presence of the last reset and rejected when a
// command arrived while an operation was running.
// Path: a tick beat is registered in the input register, stepped through
// the timing state machine and lands in the result register, from which its
// result beat is offered.
// Throughput is one beat per cycle while res is taken, as the state update
// between the input and result registers is combinational.
// Stall: if res is not taken, the result register holds, the input register
// fills and tick.ready drops until the result moves on; nothing is lost.
// Reset: rst_n clears the valid flags of both pipeline registers, returns
// the state machine to idle, loads the default timing values. Configuration
// writes (cfg_we, cfg_index, cfg_wdata) are meant for idle periods only.
module one_wire_bus_master_unit
    import owb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    owb_tick_if.sink             tick,
    owb_res_if.source            res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t  cfg;
    tick_t in_reg;
    logic  in_valid_reg;
    res_t  out_reg;
    logic  out_valid_reg;
    res_t  step_res;
    logic  advance;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick.ready)
                in_valid_reg <= tick.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
            in_reg <= '{cmd: tick.cmd, tx_byte: tick.tx_byte, line_in: tick.line_in};
        if (advance)
            out_reg <= step_res;
    end

    owb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    owb_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .tick    (in_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign res.valid     = out_valid_reg;
    assign res.drive_low = out_reg.drive_low;
    assign res.busy_res  = out_reg.busy_res;
    assign res.done_res  = out_reg.done_res;
    assign res.rx_byte   = out_reg.rx_byte;
    assign res.presence  = out_reg.presence;
    assign res.rejected  = out_reg.rejected;

endmodule
